// ===== rtl/sfrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types and constants of the spreading factor rate controller.
// ----------------------------------------------------------------------------
package sfrc_pkg;

   // SNR window
   localparam int SNR_WINDOW = 20;
   localparam int WIN_ADDR_W = (SNR_WINDOW > 1) ? $clog2(SNR_WINDOW) : 1;
   localparam int WIN_CNT_W  = $clog2(SNR_WINDOW + 1);
   localparam int SNR_W      = 10;
   localparam logic signed [SNR_W-1:0] SNR_FLOOR = -10'sd20;
   localparam int SNR_OFFSET = 10;
   localparam int SNR_STEP   = 3;

   // factor range
   localparam int          SF_W   = 3;
   localparam logic [2:0]  TOP_SF = 3'd5;

   // period evaluation
   localparam int         PERIOD_W       = 16;
   localparam logic [9:0] PERMILLE_SCALE = 10'd1000;
   localparam logic [5:0] HYST_PERMILLE  = 6'd50;

   // register indexes
   localparam logic [1:0] CSR_SF_MODE    = 2'd0;
   localparam logic [1:0] CSR_STATIC_SF  = 2'd1;
   localparam logic [1:0] CSR_PERIOD_LEN = 2'd2;
   localparam logic [1:0] CSR_TARGET     = 2'd3;

   // mode codes
   localparam logic [1:0] MODE_STATIC   = 2'd0;
   localparam logic [1:0] MODE_RELIABLE = 2'd1;
   localparam logic [1:0] MODE_WINDOW   = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_MAP,
      ST_APPLY,
      ST_EVAL
   } sfrc_state_type;

   // control from sequencer to period evaluator
   typedef struct packed {
      logic update;   // count this request
      logic commit;   // latch ratio flags of a closed period
      logic dlv;      // delivered at chosen factor
   } eval_ctl_type;

   // status from period evaluator
   typedef struct packed {
      logic closes;      // next counted request closes the period
      logic closed;      // last counted request closed the period
      logic ratio_low;
      logic ratio_high;
      logic below;       // closed period under target
   } eval_sts_type;

endpackage

// ===== rtl/sfrc_snr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_snr_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfrc_snr_ram #(
   parameter int DEPTH  = 20,
   parameter int WIDTH  = 10,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wen,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              ren,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sfrc_period_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_period_eval
// Period counters and delivery ratio check by cross-multiplication.
// ----------------------------------------------------------------------------
module sfrc_period_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [sfrc_pkg::PERIOD_W-1:0] period_length,
   input  logic [9:0]                   target_permille,
   input  sfrc_pkg::eval_ctl_type       ctl,
   output sfrc_pkg::eval_sts_type       sts
);

   logic [15:0] items_ff, items_in;
   logic [15:0] succ_ff, succ_in;
   logic        low_ff, low_in;
   logic        high_ff, high_in;
   logic        closed_ff, closed_in;
   logic [26:0] got_ff, got_in;
   logic [26:0] lo_ff, lo_in;
   logic [27:0] hi_ff, hi_in;

   logic [16:0] plen;
   logic [16:0] next_items;
   logic [16:0] succ_next;
   logic        closes;
   logic [10:0] target_hi;
   logic        cmp_low;
   logic        cmp_high;

   // period close check, a zero length means 65536
   assign plen       = (period_length == '0) ? 17'h10000 : {1'b0, period_length};
   assign next_items = {1'b0, items_ff} + 17'd1;
   assign succ_next  = {1'b0, succ_ff} + {16'd0, ctl.dlv};
   assign closes     = (next_items >= plen);
   assign target_hi  = {1'b0, target_permille} + {5'd0, sfrc_pkg::HYST_PERMILLE};

   // compare of registered products
   assign cmp_low  = (got_ff < lo_ff);
   assign cmp_high = ({1'b0, got_ff} > hi_ff);

   // counters and products
   always_comb begin
      items_in  = items_ff;
      succ_in   = succ_ff;
      closed_in = closed_ff;
      got_in    = got_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      if (ctl.update) begin
         closed_in = closes;
         got_in    = 27'(succ_next) * 27'(sfrc_pkg::PERMILLE_SCALE);
         lo_in     = 27'(target_permille) * 27'(next_items);
         hi_in     = 28'(target_hi) * 28'(next_items);
         if (closes) begin
            items_in = '0;
            succ_in  = '0;
         end else begin
            items_in = next_items[15:0];
            succ_in  = succ_next[15:0];
         end
      end
   end

   // ratio flags of the last closed period
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctl.commit && closed_ff) begin
         low_in  = cmp_low;
         high_in = cmp_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff  <= '0;
         succ_ff   <= '0;
         low_ff    <= 1'b0;
         high_ff   <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         items_ff  <= items_in;
         succ_ff   <= succ_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         closed_ff <= closed_in;
      end
   end

   // products carry no reset
   always_ff @(posedge clock) begin
      got_ff <= got_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   assign sts.closes     = closes;
   assign sts.closed     = closed_ff;
   assign sts.ratio_low  = low_ff;
   assign sts.ratio_high = high_ff;
   assign sts.below      = closed_ff & cmp_low;

endmodule

// ===== rtl/spreading_factor_rate_controller_core.sv =====
`timescale 1ns / 1ps
// Sequence: static, reliability, warmup and after-miss cases pass IDLE, WRITE,
//   APPLY and EVAL; a walk of the window maximum adds SCAN and MAP after WRITE.
// Overlap: a new request is taken only after the last result is loaded; it is
//   taken while that result waits in the output register.
// Reset: synchronous; control and configuration registers to defaults, counters
//   cleared, SNR memory contents not cleared (no clearing pass).
// ----------------------------------------------------------------------------
// spreading_factor_rate_controller_core
// Picks a spreading factor per packet record in static, reliability stepping
// or SNR window mode and reports delivery, packet weights and period status.
// ----------------------------------------------------------------------------
module spreading_factor_rate_controller_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // signal_level[8:0], noise_level[17:9], success_map[23:18]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // chosen_sf[2:0], delivered[3], delivered_packets[8:4],
                                    // best_packets[13:9], below_target[14], zero[15]
   output logic        rsp_tlast    // period_end
);

   localparam int AW = sfrc_pkg::WIN_ADDR_W;
   localparam int CW = sfrc_pkg::WIN_CNT_W;

   // configuration registers
   logic [1:0]  sf_mode_ff;
   logic [2:0]  static_sf_ff;
   logic [15:0] period_length_ff;
   logic [9:0]  target_ff;

   // sequencer and item state
   sfrc_pkg::sfrc_state_type state_ff, state_in;
   logic [2:0]                sf_ff, sf_in;
   logic                      prev_dlv_ff, prev_dlv_in;
   logic [8:0]                held_sig_ff, held_sig_in;
   logic [8:0]                held_noise_ff, held_noise_in;
   logic [5:0]                map_ff, map_in;
   logic [AW-1:0]             win_pos_ff, win_pos_in;
   logic [CW-1:0]             warmup_ff, warmup_in;
   logic [CW-1:0]             scan_cnt_ff, scan_cnt_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      rd_last_ff, rd_last_in;
   logic signed [sfrc_pkg::SNR_W-1:0] max_ff, max_in;

   // output register
   logic        rsp_vld_ff, rsp_vld_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // sequencer outputs
   logic                    accept;
   logic                    ram_wen;
   logic                    ram_ren;
   logic                    out_load;
   sfrc_pkg::eval_ctl_type  eval_ctl;
   sfrc_pkg::eval_sts_type  eval_sts;

   logic [sfrc_pkg::SNR_W-1:0] ram_rdata;
   logic [sfrc_pkg::SNR_W-1:0] snr;
   logic                       scan_go;
   logic                       out_free;
   logic                       dlv;
   logic [4:0]                 dlv_pkts;
   logic [4:0]                 best_pkts;
   logic [2:0]                 step_sf;

   // packet weight per factor index
   function automatic logic [4:0] pkt_weight(input logic [2:0] idx);
      logic [4:0] w;
      case (idx)
         3'd0:    w = 5'd20;
         3'd1:    w = 5'd12;
         3'd2:    w = 5'd7;
         3'd3:    w = 5'd4;
         3'd4:    w = 5'd2;
         3'd5:    w = 5'd1;
         default: w = 5'd0;
      endcase
      return w;
   endfunction

   // window maximum to factor: (max + offset) / step against a threshold ladder
   function automatic logic [2:0] map_snr(input logic signed [sfrc_pkg::SNR_W-1:0] m);
      logic signed [sfrc_pkg::SNR_W:0] v;
      logic [2:0]                      r;
      v = {m[sfrc_pkg::SNR_W-1], m} + (sfrc_pkg::SNR_W+1)'(sfrc_pkg::SNR_OFFSET);
      r = 3'd0;
      for (int i = int'(sfrc_pkg::TOP_SF) - 1; i >= 0; i--) begin
         if (v < $signed((sfrc_pkg::SNR_W+1)'((i + 1) * sfrc_pkg::SNR_STEP))) begin
            r = 3'(int'(sfrc_pkg::TOP_SF) - i);
         end
      end
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sf_mode_ff       <= sfrc_pkg::MODE_WINDOW;
         static_sf_ff     <= 3'd5;
         period_length_ff <= 16'd300;
         target_ff        <= 10'd800;
      end else if (csr_wen) begin
         case (csr_index)
            sfrc_pkg::CSR_SF_MODE:    sf_mode_ff       <= csr_wdata[1:0];
            sfrc_pkg::CSR_STATIC_SF:  static_sf_ff     <= csr_wdata[2:0];
            sfrc_pkg::CSR_PERIOD_LEN: period_length_ff <= csr_wdata;
            sfrc_pkg::CSR_TARGET:     target_ff        <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign snr      = {held_sig_ff[8], held_sig_ff} - {held_noise_ff[8], held_noise_ff};
   assign scan_go  = (sf_mode_ff == sfrc_pkg::MODE_WINDOW) && prev_dlv_ff &&
                     (warmup_ff >= CW'(sfrc_pkg::SNR_WINDOW));
   assign out_free = !rsp_vld_ff || rsp_tready;

   // delivery and weights at the chosen factor
   always_comb begin
      dlv       = map_ff[sf_ff];
      dlv_pkts  = dlv ? pkt_weight(sf_ff) : 5'd0;
      best_pkts = 5'd0;
      for (int k = 5; k >= 0; k--) begin
         if (map_ff[k]) begin
            best_pkts = pkt_weight(3'(k));
         end
      end
   end

   // reliability stepping at a period close
   always_comb begin
      step_sf = sf_ff;
      if (eval_sts.closes) begin
         if (eval_sts.ratio_low && (step_sf < sfrc_pkg::TOP_SF)) begin
            step_sf = step_sf + 3'd1;
         end
         if (eval_sts.ratio_high && (step_sf != 3'd0)) begin
            step_sf = step_sf - 3'd1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfrc_pkg::ST_IDLE:  if (req_tvalid) state_in = sfrc_pkg::ST_WRITE;
         sfrc_pkg::ST_WRITE: state_in = scan_go ? sfrc_pkg::ST_SCAN : sfrc_pkg::ST_APPLY;
         sfrc_pkg::ST_SCAN:  if (rd_last_ff) state_in = sfrc_pkg::ST_MAP;
         sfrc_pkg::ST_MAP:   state_in = sfrc_pkg::ST_APPLY;
         sfrc_pkg::ST_APPLY: state_in = sfrc_pkg::ST_EVAL;
         sfrc_pkg::ST_EVAL:  if (out_free) state_in = sfrc_pkg::ST_IDLE;
         default:            state_in = sfrc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready      = 1'b0;
      ram_wen         = 1'b0;
      ram_ren         = 1'b0;
      out_load        = 1'b0;
      eval_ctl.update = 1'b0;
      eval_ctl.commit = 1'b0;
      eval_ctl.dlv    = dlv;
      case (state_ff)
         sfrc_pkg::ST_IDLE:  req_tready = 1'b1;
         sfrc_pkg::ST_WRITE: ram_wen = (sf_mode_ff == sfrc_pkg::MODE_WINDOW);
         sfrc_pkg::ST_SCAN:  ram_ren = (scan_cnt_ff < CW'(sfrc_pkg::SNR_WINDOW));
         sfrc_pkg::ST_APPLY: eval_ctl.update = 1'b1;
         sfrc_pkg::ST_EVAL: begin
            eval_ctl.commit = 1'b1;
            out_load        = out_free;
         end
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // item datapath
   always_comb begin
      sf_in         = sf_ff;
      prev_dlv_in   = prev_dlv_ff;
      held_sig_in   = held_sig_ff;
      held_noise_in = held_noise_ff;
      map_in        = map_ff;
      win_pos_in    = win_pos_ff;
      warmup_in     = warmup_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = 1'b0;
      max_in        = max_ff;

      // capture request; levels held while the last packet failed
      if (accept) begin
         map_in = req_tdata[23:18];
         if (prev_dlv_ff) begin
            held_sig_in   = req_tdata[8:0];
            held_noise_in = req_tdata[17:9];
         end
      end

      // factor selection without the window walk
      if (state_ff == sfrc_pkg::ST_WRITE) begin
         win_pos_in = (win_pos_ff == AW'(sfrc_pkg::SNR_WINDOW - 1)) ? '0 :
                      win_pos_ff + AW'(1);
         if (warmup_ff < CW'(sfrc_pkg::SNR_WINDOW)) begin
            warmup_in = warmup_ff + CW'(1);
         end
         scan_cnt_in = '0;
         max_in      = sfrc_pkg::SNR_FLOOR;
         case (sf_mode_ff)
            sfrc_pkg::MODE_STATIC:
               sf_in = (static_sf_ff > sfrc_pkg::TOP_SF) ? sfrc_pkg::TOP_SF : static_sf_ff;
            sfrc_pkg::MODE_RELIABLE:
               sf_in = step_sf;
            sfrc_pkg::MODE_WINDOW:
               if (!prev_dlv_ff && (sf_ff < sfrc_pkg::TOP_SF)) begin
                  sf_in = sf_ff + 3'd1;
               end
            default: ;
         endcase
      end

      // window walk: issue one read a cycle, fold returned data
      if (state_ff == sfrc_pkg::ST_SCAN) begin
         if (ram_ren) begin
            scan_cnt_in = scan_cnt_ff + CW'(1);
            rd_last_in  = (scan_cnt_ff == CW'(sfrc_pkg::SNR_WINDOW - 1));
         end
         rd_vld_in = ram_ren;
         if (rd_vld_ff && ($signed(ram_rdata) > max_ff)) begin
            max_in = $signed(ram_rdata);
         end
      end

      if (state_ff == sfrc_pkg::ST_MAP) begin
         sf_in = map_snr(max_ff);
      end

      if (state_ff == sfrc_pkg::ST_APPLY) begin
         prev_dlv_in = dlv;
      end
   end

   // output register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (out_load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {1'b0, eval_sts.below, best_pkts, dlv_pkts, dlv, sf_ff};
         rsp_last_in = eval_sts.closed;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfrc_pkg::ST_IDLE;
         sf_ff         <= 3'd0;
         prev_dlv_ff   <= 1'b1;
         held_sig_ff   <= '0;
         held_noise_ff <= '0;
         win_pos_ff    <= '0;
         warmup_ff     <= '0;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sf_ff         <= sf_in;
         prev_dlv_ff   <= prev_dlv_in;
         held_sig_ff   <= held_sig_in;
         held_noise_ff <= held_noise_in;
         win_pos_ff    <= win_pos_in;
         warmup_ff     <= warmup_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      map_ff      <= map_in;
      max_ff      <= max_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // SNR window memory
   sfrc_snr_ram #(
      .DEPTH  (sfrc_pkg::SNR_WINDOW),
      .WIDTH  (sfrc_pkg::SNR_W),
      .ADDR_W (AW)
   ) u_snr_ram (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (win_pos_ff),
      .wdata (snr),
      .ren   (ram_ren),
      .raddr (scan_cnt_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // period counters and ratio flags
   sfrc_period_eval u_period_eval (
      .clock           (clock),
      .reset           (reset),
      .period_length   (period_length_ff),
      .target_permille (target_ff),
      .ctl             (eval_ctl),
      .sts             (eval_sts)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
